>>> rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers, empty when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, c)
`define ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

>>> rtl/core/ddo_pkg.sv
// ---------------------------------------------------------------------------
// Odometry package
// Shared constants, arctangent table and controller/datapath command types.
// ---------------------------------------------------------------------------
`default_nettype none
package ddo_pkg;
    localparam int ATAN_ENTRIES = 24;
    localparam int ROTATION_STEPS_DEFAULT = 16;
    localparam logic [31:0] CORDIC_START = 32'd652032874;
    localparam logic [15:0] RADIUS_RESET = 16'd256;
    localparam logic [31:0] GAIN_RESET = 32'd683565276;
    localparam logic [14:0] MAXSPD_RESET = 15'd32767;
    localparam logic [1:0] REG_RADIUS = 2'd0;
    localparam logic [1:0] REG_GAIN = 2'd1;
    localparam logic [1:0] REG_MAXSPD = 2'd2;
    localparam logic OP_STEP = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    typedef struct packed {
        logic load;
        logic start;
        logic mul1;
        logic mul2;
        logic rot_init;
        logic rot_step;
        logic mul_pos;
        logic mul_head;
        logic commit;
    } ddo_cmd_t;

    function automatic logic [31:0] atan_lookup(input logic [4:0] i);
        logic [31:0] r;
        begin
            unique case (i)
                5'd0: r = 32'd536870912;  5'd1: r = 32'd316933406;
                5'd2: r = 32'd167458907;  5'd3: r = 32'd85004756;
                5'd4: r = 32'd42667331;   5'd5: r = 32'd21354465;
                5'd6: r = 32'd10680862;   5'd7: r = 32'd5340245;
                5'd8: r = 32'd2670163;    5'd9: r = 32'd1335087;
                5'd10: r = 32'd667544;    5'd11: r = 32'd333772;
                5'd12: r = 32'd166886;    5'd13: r = 32'd83443;
                5'd14: r = 32'd41722;     5'd15: r = 32'd20861;
                5'd16: r = 32'd10430;     5'd17: r = 32'd5215;
                5'd18: r = 32'd2608;      5'd19: r = 32'd1304;
                5'd20: r = 32'd652;       5'd21: r = 32'd326;
                5'd22: r = 32'd163;       5'd23: r = 32'd81;
                default: r = 32'd0;
            endcase
            atan_lookup = r;
        end
    endfunction
endpackage
`default_nettype wire

>>> rtl/core/ddo_datapath.sv
// ---------------------------------------------------------------------------
// Odometry datapath
// Speed clamp, travel products, CORDIC iteration and pose update registers.
// ---------------------------------------------------------------------------
`default_nettype none
module ddo_datapath (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire ddo_pkg::ddo_cmd_t cmd,
    input  wire logic [4:0]        iter,
    input  wire logic [15:0]       left_speed,
    input  wire logic [15:0]       right_speed,
    input  wire logic [15:0]       time_step,
    input  wire logic [31:0]       load_x,
    input  wire logic [31:0]       load_y,
    input  wire logic [15:0]       load_heading,
    input  wire logic [15:0]       wheel_radius,
    input  wire logic [31:0]       turn_gain,
    input  wire logic [14:0]       max_wheel_speed,
    output logic [31:0]            pos_x,
    output logic [31:0]            pos_y,
    output logic [15:0]            heading,
    output logic [14:0]            left_app,
    output logic [14:0]            right_app
);
    logic [14:0] l_reg, r_reg;
    logic [15:0] dt_reg;
    logic [30:0] pl_reg, pr_reg;
    logic [31:0] tl_reg, tr_reg;
    logic signed [33:0] cx_reg, cy_reg;
    logic signed [32:0] z_reg;
    logic flip_reg;
    logic signed [63:0] px_reg, py_reg;
    logic [63:0] ph_reg;
    logic [31:0] x_reg, y_reg;
    logic [15:0] h_reg;
    logic [14:0] la_reg, ra_reg;

    logic [14:0] lc, rc;
    logic [31:0] ang;
    logic signed [32:0] z0;
    logic signed [33:0] xs, ys;
    logic signed [32:0] at;
    logic [31:0] mean;
    logic signed [32:0] diff;
    logic signed [33:0] cf, sf;

    always_comb
    begin
        lc = left_speed[15] ? 15'd0 :
             (left_speed[14:0] > max_wheel_speed ? max_wheel_speed : left_speed[14:0]);
        rc = right_speed[15] ? 15'd0 :
             (right_speed[14:0] > max_wheel_speed ? max_wheel_speed : right_speed[14:0]);
        ang = {heading, 16'd0};
        z0 = $signed({ang[31], ang});
        xs = cx_reg >>> iter;
        ys = cy_reg >>> iter;
        at = $signed({1'b0, ddo_pkg::atan_lookup(iter)});
        mean = 32'((33'(tl_reg) + 33'(tr_reg)) >> 1);
        diff = $signed({1'b0, tr_reg}) - $signed({1'b0, tl_reg});
        cf = flip_reg ? -cx_reg : cx_reg;
        sf = flip_reg ? -cy_reg : cy_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            l_reg <= lc;
            r_reg <= rc;
            dt_reg <= time_step;
        end
        if (cmd.mul1)
        begin
            pl_reg <= 31'(l_reg) * 31'(dt_reg);
            pr_reg <= 31'(r_reg) * 31'(dt_reg);
        end
        if (cmd.mul2)
        begin
            tl_reg <= 32'((47'(pl_reg) * 47'(wheel_radius)) >> 16);
            tr_reg <= 32'((47'(pr_reg) * 47'(wheel_radius)) >> 16);
        end
        if (cmd.rot_init)
        begin
            cx_reg <= $signed({2'b00, ddo_pkg::CORDIC_START});
            cy_reg <= '0;
            if (z0 > 33'sd1073741824 || z0 < -33'sd1073741824)
            begin
                z_reg <= $signed({~ang[31], ~ang[31], ang[30:0]});
                flip_reg <= 1'b1;
            end
            else
            begin
                z_reg <= z0;
                flip_reg <= 1'b0;
            end
        end
        else if (cmd.rot_step)
        begin
            if (!z_reg[32])
            begin
                cx_reg <= cx_reg - ys;
                cy_reg <= cy_reg + xs;
                z_reg <= z_reg - at;
            end
            else
            begin
                cx_reg <= cx_reg + ys;
                cy_reg <= cy_reg - xs;
                z_reg <= z_reg + at;
            end
        end
        if (cmd.mul_pos)
        begin
            px_reg <= $signed(64'(mean)) * 64'(cf);
            py_reg <= $signed(64'(mean)) * 64'(sf);
        end
        if (cmd.mul_head)
            ph_reg <= 64'(diff) * $signed(64'(turn_gain));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg <= '0;
            y_reg <= '0;
            h_reg <= '0;
            la_reg <= '0;
            ra_reg <= '0;
        end
        else if (cmd.load)
        begin
            x_reg <= load_x;
            y_reg <= load_y;
            h_reg <= load_heading;
            la_reg <= '0;
            ra_reg <= '0;
        end
        else if (cmd.commit)
        begin
            x_reg <= x_reg + px_reg[61:30];
            y_reg <= y_reg + py_reg[61:30];
            h_reg <= h_reg + ph_reg[47:32];
            la_reg <= l_reg;
            ra_reg <= r_reg;
        end
    end

    assign pos_x = x_reg;
    assign pos_y = y_reg;
    assign heading = h_reg;
    assign left_app = la_reg;
    assign right_app = ra_reg;
endmodule
`default_nettype wire

>>> rtl/core/ddo_ctrl.sv
// ---------------------------------------------------------------------------
// Odometry controller
// Sequences pose load, clamp, travel multiplies, rotation iterations and pose commit.
// ---------------------------------------------------------------------------
`default_nettype none
module ddo_ctrl #(
    parameter int ROTATION_STEPS = ddo_pkg::ROTATION_STEPS_DEFAULT
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    input  wire logic         in_op,
    input  wire logic         out_stall,
    output logic              in_stall,
    output logic              out_valid,
    output ddo_pkg::ddo_cmd_t cmd,
    output logic [4:0]        iter
);
    localparam int STEPS = (ROTATION_STEPS > ddo_pkg::ATAN_ENTRIES) ?
                           ddo_pkg::ATAN_ENTRIES : ROTATION_STEPS;
    localparam logic [4:0] LAST = 5'(STEPS - 1);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL1 = 3'd1;
    localparam logic [2:0] S_MUL2 = 3'd2;
    localparam logic [2:0] S_ROT  = 3'd3;
    localparam logic [2:0] S_MULP = 3'd4;
    localparam logic [2:0] S_COMMIT = 3'd5;

    logic [2:0] state_reg, state_next;
    logic [4:0] iter_reg, iter_next;
    logic out_valid_reg, out_valid_next;
    logic accept;

    always_comb
    begin
        in_stall = (state_reg != S_IDLE) || (out_valid_reg && out_stall);
        accept = in_valid && !in_stall;
        cmd = '0;
        state_next = state_reg;
        iter_next = iter_reg;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (in_op == ddo_pkg::OP_LOAD)
                    begin
                        cmd.load = 1'b1;
                        out_valid_next = 1'b1;
                    end
                    else
                    begin
                        cmd.start = 1'b1;
                        cmd.rot_init = 1'b1;
                        state_next = S_MUL1;
                    end
                end
            end
            S_MUL1:
            begin
                cmd.mul1 = 1'b1;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                cmd.mul2 = 1'b1;
                iter_next = '0;
                state_next = S_ROT;
            end
            S_ROT:
            begin
                cmd.rot_step = 1'b1;
                iter_next = iter_reg + 5'd1;
                if (iter_reg == LAST)
                    state_next = S_MULP;
            end
            S_MULP:
            begin
                cmd.mul_pos = 1'b1;
                cmd.mul_head = 1'b1;
                state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                cmd.commit = 1'b1;
                out_valid_next = 1'b1;
                state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            iter_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            iter_reg <= iter_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign iter = iter_reg;
endmodule
`default_nettype wire

>>> rtl/core/differential_drive_odometry_unit.sv
// ---------------------------------------------------------------------------
// Differential drive odometry unit
// Dead-reckoning pose tracker with CORDIC heading rotation.
// ---------------------------------------------------------------------------
// A step transaction runs the clamp, travel multiplies, ROTATION_STEPS CORDIC
// iterations (at most 24), position and heading multiplies and pose commit; a load
// transaction gives its result in the cycle after acceptance. One transaction is in
// flight at a time, and the next is accepted at the earliest in the cycle in which
// the result is taken.
`default_nettype none
`include "assert_macros.svh"
module differential_drive_odometry_unit #(
    parameter int ROTATION_STEPS = ddo_pkg::ROTATION_STEPS_DEFAULT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        operation,
    input  wire logic [15:0] left_speed,
    input  wire logic [15:0] right_speed,
    input  wire logic [15:0] time_step,
    input  wire logic [31:0] load_x,
    input  wire logic [31:0] load_y,
    input  wire logic [15:0] load_heading,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [31:0]      out_x,
    output logic [31:0]      out_y,
    output logic [15:0]      out_heading,
    output logic [14:0]      left_applied,
    output logic [14:0]      right_applied,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);
    ddo_pkg::ddo_cmd_t cmd;
    logic [4:0] iter;
    logic [15:0] radius_reg;
    logic [31:0] gain_reg;
    logic [14:0] maxspd_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= ddo_pkg::RADIUS_RESET;
            gain_reg <= ddo_pkg::GAIN_RESET;
            maxspd_reg <= ddo_pkg::MAXSPD_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == ddo_pkg::REG_RADIUS)
                radius_reg <= cfg_data[15:0];
            else if (cfg_index == ddo_pkg::REG_GAIN)
                gain_reg <= cfg_data;
            else if (cfg_index == ddo_pkg::REG_MAXSPD)
                maxspd_reg <= cfg_data[14:0];
        end
    end

    ddo_ctrl #(.ROTATION_STEPS(ROTATION_STEPS)) u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_op(operation),
        .out_stall(out_stall), .in_stall(in_stall), .out_valid(out_valid),
        .cmd(cmd), .iter(iter)
    );

    ddo_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .iter(iter),
        .left_speed(left_speed), .right_speed(right_speed), .time_step(time_step),
        .load_x(load_x), .load_y(load_y), .load_heading(load_heading),
        .wheel_radius(radius_reg), .turn_gain(gain_reg), .max_wheel_speed(maxspd_reg),
        .pos_x(out_x), .pos_y(out_y), .heading(out_heading),
        .left_app(left_applied), .right_app(right_applied)
    );

    `ASSERT_IMPLIES(a_load_applied_zero, clk, rst_n, out_valid && $past(cmd.load), left_applied == 15'd0 && right_applied == 15'd0)
    `ASSERT_NEXT(a_commit_valid, clk, rst_n, cmd.commit, out_valid)
    `ASSERT_IMPLIES(a_stall_busy, clk, rst_n, cmd.rot_step, in_stall)
endmodule
`default_nettype wire
